FILE: sv/dvi_pkg.sv
// Shared constants for the vertex deduplication indexer.
package dvi_pkg;
	localparam int MAX_UNIQUE_DEF = 4096;
	localparam int MAX_WORDS_DEF  = 17;
	localparam int WORD_W         = 32;
	localparam int INDEX_W        = 12;
	localparam int CFG_W          = 5;
	localparam logic [CFG_W-1:0] RECORD_WORDS_RST = 5'd17;
	localparam logic ACT_WORD  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;
endpackage

FILE: sv/vertex_dedup_indexer.sv
// Top level of the vertex deduplication indexer: scan control and result register.
// Flow: a record's last word starts a scan that reads the stored rows in order; a match on
// row k returns k, else the record is stored as a new row or table_full is set when full.
// Throughput: one word per cycle while no scan runs; every transaction is held during a
// scan, and a completing word also waits for the result register to drain.
// Reset: clears word count, unique count and scan control; store contents never read unwritten.
module vertex_dedup_indexer #(
	parameter int MAX_UNIQUE = dvi_pkg::MAX_UNIQUE_DEF,
	parameter int MAX_WORDS  = dvi_pkg::MAX_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dvi_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         action,
	input  logic [dvi_pkg::WORD_W-1:0]   attr_word,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [dvi_pkg::INDEX_W-1:0]  vertex_index,
	output logic                         is_new,
	output logic                         table_full
);
	import dvi_pkg::*;

	localparam int LW  = $clog2(MAX_WORDS + 1);
	localparam int AW  = $clog2(MAX_UNIQUE);
	localparam int CW  = $clog2(MAX_UNIQUE + 1);
	localparam int RW  = MAX_WORDS * WORD_W;

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [LW-1:0]     eff_len;
	logic              rec_done;
	logic [RW-1:0]     record_q;
	logic [RW-1:0]     rdata_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic              pend_s1;
	logic [CW-1:0]     pidx_s1;
	logic              accept;
	logic              push;
	logic              clear;
	logic              issue;
	logic              hit;
	logic              miss;
	logic              store_we;

	// record length register; out-of-range values clamp to 1..MAX_WORDS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= RECORD_WORDS_RST;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			eff_len = LW'(1);
		end else if (6'(cfg_q) > 6'(MAX_WORDS)) begin
			eff_len = LW'(MAX_WORDS);
		end else begin
			eff_len = LW'(cfg_q);
		end
	end

	// hold everything during a scan; hold a completing word while a result is pending
	assign item_stall = (state_q == ST_SCAN) ||
		(result_valid && action == ACT_WORD && rec_done);
	assign accept = item_valid && !item_stall;
	assign push   = accept && action == ACT_WORD;
	assign clear  = accept && action == ACT_CLEAR;

	dvi_asm #(.MAX_WORDS(MAX_WORDS), .LW(LW)) u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.clear    (clear),
		.word     (attr_word),
		.eff_len  (eff_len),
		.done     (rec_done),
		.record_q (record_q)
	);

	// scan: issue one row read per cycle, compare the row returned in the next cycle
	assign issue    = (state_q == ST_SCAN) && (ptr_q < count_q);
	assign hit      = (state_q == ST_SCAN) && pend_s1 && (rdata_q == record_q);
	assign miss     = (state_q == ST_SCAN) && !pend_s1 && !issue;
	assign store_we = miss && (count_q < CW'(MAX_UNIQUE));

	dvi_store #(.DEPTH(MAX_UNIQUE), .WIDTH(RW), .AW(AW)) u_store (
		.clk     (clk),
		.we      (store_we),
		.waddr   (count_q[AW-1:0]),
		.wdata   (record_q),
		.re      (issue),
		.raddr   (ptr_q[AW-1:0]),
		.rdata_q (rdata_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			pend_s1      <= 1'b0;
			pidx_s1      <= '0;
			result_valid <= 1'b0;
			vertex_index <= '0;
			is_new       <= 1'b0;
			table_full   <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			// drop the read in flight once a hit ends the scan
			pend_s1 <= issue && !hit;
			pidx_s1 <= ptr_q;
			case (state_q)
				ST_IDLE: begin
					if (clear) begin
						count_q <= '0;
					end else if (push && rec_done) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (hit) begin
						result_valid <= 1'b1;
						vertex_index <= INDEX_W'(pidx_s1);
						is_new       <= 1'b0;
						table_full   <= 1'b0;
						state_q      <= ST_IDLE;
					end else if (miss) begin
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
						if (store_we) begin
							vertex_index <= INDEX_W'(count_q);
							is_new       <= 1'b1;
							table_full   <= 1'b0;
							count_q      <= count_q + CW'(1);
						end else begin
							vertex_index <= '0;
							is_new       <= 1'b0;
							table_full   <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/dvi_asm.sv
// Record assembly buffer: collects attribute words and emits a zero-padded record.
module dvi_asm #(
	parameter int MAX_WORDS = dvi_pkg::MAX_WORDS_DEF,
	parameter int LW        = $clog2(MAX_WORDS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 clear,
	input  logic [dvi_pkg::WORD_W-1:0]           word,
	input  logic [LW-1:0]                        eff_len,
	output logic                                 done,
	output logic [MAX_WORDS*dvi_pkg::WORD_W-1:0] record_q
);
	import dvi_pkg::*;

	logic [WORD_W-1:0] buf_q [MAX_WORDS];
	logic [LW-1:0]     wc_q;
	logic [LW-1:0]     wc_inc;
	logic [MAX_WORDS*WORD_W-1:0] padded;

	assign wc_inc = (wc_q < LW'(MAX_WORDS)) ? wc_q + LW'(1) : wc_q;
	assign done   = (wc_inc >= eff_len);

	// words past the received count read as zero
	always_comb begin
		for (int j = 0; j < MAX_WORDS; j++) begin
			if (LW'(j) < wc_q) begin
				padded[j*WORD_W +: WORD_W] = buf_q[j];
			end else if (LW'(j) == wc_q) begin
				padded[j*WORD_W +: WORD_W] = word;
			end else begin
				padded[j*WORD_W +: WORD_W] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
		end else if (clear) begin
			wc_q <= '0;
		end else if (push) begin
			wc_q <= done ? '0 : wc_inc;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_WORDS; j++) begin
			if (push && LW'(j) == wc_q) begin
				buf_q[j] <= word;
			end
		end
		if (push && done) begin
			record_q <= padded;
		end
	end
endmodule

FILE: sv/dvi_store.sv
// Unique record store: one record per row, registered read.
module dvi_store #(
	parameter int DEPTH = dvi_pkg::MAX_UNIQUE_DEF,
	parameter int WIDTH = dvi_pkg::MAX_WORDS_DEF * dvi_pkg::WORD_W,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

FILE: sv/dvi_checker.sv
// Port-level checks for the vertex deduplication indexer, bound to the top level.
module dvi_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [dvi_pkg::INDEX_W-1:0] vertex_index,
	input logic                        is_new,
	input logic                        table_full
);
	import dvi_pkg::*;

	a_new_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_new && table_full))
		else $error("is_new and table_full both set");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && table_full) |-> (vertex_index == '0))
		else $error("table_full with non-zero index");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(vertex_index)
			&& $stable(is_new) && $stable(table_full)))
		else $error("stalled result changed");
endmodule

bind vertex_dedup_indexer dvi_checker u_dvi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.vertex_index (vertex_index),
	.is_new       (is_new),
	.table_full   (table_full)
);
